### src/bhm_pkg.sv
`default_nettype none

package bhm_pkg;

	localparam int BINS_DEF  = 16;
	localparam int RUNS_DEF  = 4;
	localparam int MAX_RUNS  = 4;
	localparam int VAL_W     = 16;
	localparam int STEP_W    = 11;
	localparam int CNT_W     = 32;
	localparam int TOT_W     = 38;
	localparam int RSUM_W    = 34;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] OP_COUNT = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_DUMP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd2;

	typedef struct packed {
		logic [1:0]              opcode;
		logic signed [VAL_W-1:0] value;
		logic [1:0]              run;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] bin_value;
		logic [CNT_W-1:0]        count_0;
		logic [CNT_W-1:0]        count_1;
		logic [CNT_W-1:0]        count_2;
		logic [CNT_W-1:0]        count_3;
		logic [TOT_W-1:0]        grand_total;
		logic                    is_last;
		logic                    error;
	} res_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DSTART,
		ST_DIV,
		ST_NB,
		ST_CHK,
		ST_RD,
		ST_DRD,
		ST_DCHK,
		ST_DACC,
		ST_DFIN
	} state_t;

	typedef enum logic [2:0] {
		OUT_NONE,
		OUT_ERR,
		OUT_ACK,
		OUT_READ,
		OUT_ROW,
		OUT_FINAL
	} out_kind_t;

	typedef struct packed {
		logic      load;
		logic      div_start;
		logic      nb_load;
		logic      dump_init;
		logic      dump_adv;
		logic      rowsum_load;
		logic      mem_wr;
		logic      clr;
		logic      addr_dump;
		out_kind_t out_kind;
	} ctrl_t;

	typedef struct packed {
		logic       div_busy;
		logic       bad;
		logic [1:0] op;
		logic       row_nz;
		logic       dump_last;
		logic       nb_zero;
		logic       clr_last;
	} status_t;

endpackage

`default_nettype wire

### src/bhm_div.sv
`default_nettype none

module bhm_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [bhm_pkg::VAL_W-1:0]  dividend,
	input  wire logic [bhm_pkg::STEP_W-1:0] divisor,
	output logic                            busy,
	output logic [bhm_pkg::VAL_W-1:0]       quotient,
	output logic [bhm_pkg::STEP_W-1:0]      remainder
);

	localparam int CNT_W = $clog2(bhm_pkg::VAL_W);

	logic                        busy_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [bhm_pkg::VAL_W-1:0]   quo_q;
	logic [bhm_pkg::STEP_W-1:0]  rem_q;
	logic [bhm_pkg::STEP_W-1:0]  divisor_q;
	logic [bhm_pkg::STEP_W:0]    shifted;
	logic [bhm_pkg::STEP_W:0]    diff;
	logic                        ge;

	assign shifted = {rem_q, quo_q[bhm_pkg::VAL_W-1]};
	assign ge      = shifted >= {1'b0, divisor_q};
	assign diff    = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(bhm_pkg::VAL_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[bhm_pkg::VAL_W-2:0], ge};
			rem_q <= ge ? diff[bhm_pkg::STEP_W-1:0] : shifted[bhm_pkg::STEP_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

### src/bhm_ctrl.sv
`default_nettype none

module bhm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire bhm_pkg::status_t sts,
	output bhm_pkg::ctrl_t        ctl
);

	bhm_pkg::state_t state_q;
	bhm_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		ctl.out_kind = bhm_pkg::OUT_NONE;
		case (state_q)
			bhm_pkg::ST_CLEAR: begin
				ctl.mem_wr = 1'b1;
				ctl.clr    = 1'b1;
				if (sts.clr_last) begin
					state_d = bhm_pkg::ST_IDLE;
				end
			end
			bhm_pkg::ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = bhm_pkg::ST_DSTART;
				end
			end
			bhm_pkg::ST_DSTART: begin
				ctl.div_start = 1'b1;
				state_d       = bhm_pkg::ST_DIV;
			end
			bhm_pkg::ST_DIV: begin
				if (!sts.div_busy) begin
					state_d = bhm_pkg::ST_NB;
				end
			end
			bhm_pkg::ST_NB: begin
				ctl.nb_load = 1'b1;
				state_d     = bhm_pkg::ST_CHK;
			end
			bhm_pkg::ST_CHK: begin
				case (sts.op)
					bhm_pkg::OP_DUMP: begin
						ctl.dump_init = 1'b1;
						state_d = sts.nb_zero ? bhm_pkg::ST_DFIN : bhm_pkg::ST_DRD;
					end
					bhm_pkg::OP_COUNT, bhm_pkg::OP_READ: begin
						if (sts.bad) begin
							ctl.out_kind = bhm_pkg::OUT_ERR;
							state_d      = bhm_pkg::ST_IDLE;
						end else begin
							state_d = bhm_pkg::ST_RD;
						end
					end
					default: begin
						ctl.out_kind = bhm_pkg::OUT_ERR;
						state_d      = bhm_pkg::ST_IDLE;
					end
				endcase
			end
			bhm_pkg::ST_RD: begin
				if (sts.op == bhm_pkg::OP_COUNT) begin
					ctl.mem_wr   = 1'b1;
					ctl.out_kind = bhm_pkg::OUT_ACK;
				end else begin
					ctl.out_kind = bhm_pkg::OUT_READ;
				end
				state_d = bhm_pkg::ST_IDLE;
			end
			bhm_pkg::ST_DRD: begin
				ctl.addr_dump = 1'b1;
				state_d       = bhm_pkg::ST_DCHK;
			end
			bhm_pkg::ST_DCHK: begin
				ctl.addr_dump   = 1'b1;
				ctl.rowsum_load = 1'b1;
				if (sts.row_nz) begin
					ctl.out_kind = bhm_pkg::OUT_ROW;
				end
				state_d = bhm_pkg::ST_DACC;
			end
			bhm_pkg::ST_DACC: begin
				ctl.addr_dump = 1'b1;
				ctl.dump_adv  = 1'b1;
				state_d = sts.dump_last ? bhm_pkg::ST_DFIN : bhm_pkg::ST_DRD;
			end
			bhm_pkg::ST_DFIN: begin
				ctl.out_kind = bhm_pkg::OUT_FINAL;
				state_d      = bhm_pkg::ST_IDLE;
			end
			default: begin
				state_d = bhm_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != bhm_pkg::ST_IDLE);

endmodule

`default_nettype wire

### src/bhm_datapath.sv
`default_nettype none

module bhm_datapath #(
	parameter int BINS = bhm_pkg::BINS_DEF,
	parameter int RUNS = bhm_pkg::RUNS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bhm_pkg::cmd_t                 cmd_in,
	input  wire logic                          cfg_valid,
	input  wire logic [bhm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bhm_pkg::VAL_W-1:0]     cfg_data,
	input  wire bhm_pkg::ctrl_t                ctl,
	output bhm_pkg::status_t                   sts,
	output logic                               res_valid,
	output bhm_pkg::res_t                      res
);

	localparam int BIN_AW = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int NB_W   = $clog2(BINS + 1);
	localparam int ROW_W  = RUNS * bhm_pkg::CNT_W;
	localparam int LANE_W = bhm_pkg::MAX_RUNS * bhm_pkg::CNT_W;
	localparam int CW     = bhm_pkg::CNT_W;

	logic signed [bhm_pkg::VAL_W-1:0] low_q;
	logic signed [bhm_pkg::VAL_W-1:0] high_q;
	logic [bhm_pkg::STEP_W-1:0]       step_q;
	logic [bhm_pkg::STEP_W-1:0]       step_eff;

	bhm_pkg::cmd_t                    cmd_q;
	logic signed [bhm_pkg::VAL_W:0]   d1;
	logic signed [bhm_pkg::VAL_W:0]   d2;
	logic signed [bhm_pkg::VAL_W:0]   d1_neg;
	logic [bhm_pkg::VAL_W-1:0]        mag1;
	logic [bhm_pkg::VAL_W-1:0]        mag2;
	logic                             busy1;
	logic                             busy2;
	logic [bhm_pkg::VAL_W-1:0]        q1;
	logic [bhm_pkg::VAL_W-1:0]        q2;
	logic [bhm_pkg::STEP_W-1:0]       r1;
	logic [bhm_pkg::STEP_W-1:0]       r2_unused;

	logic [NB_W-1:0]                  nb_q;
	logic [NB_W-1:0]                  nb_d;
	logic [bhm_pkg::VAL_W:0]          q2p1;
	logic                             bad_range;
	logic [BIN_AW-1:0]                k;

	logic [ROW_W-1:0]                 mem [BINS];
	logic [ROW_W-1:0]                 rdata_q;
	logic [BIN_AW-1:0]                raddr;
	logic [BIN_AW-1:0]                waddr;
	logic [ROW_W-1:0]                 wdata;
	logic [BIN_AW-1:0]                clr_q;

	logic [LANE_W-1:0]                lanes;
	logic [LANE_W-1:0]                lanes_upd;
	logic [CW-1:0]                    sel_cnt;
	logic [CW-1:0]                    sel_inc;
	logic [bhm_pkg::RSUM_W-1:0]       row_sum;
	logic [bhm_pkg::RSUM_W-1:0]       row_sum_q;
	logic [bhm_pkg::TOT_W-1:0]        total_q;
	logic [bhm_pkg::TOT_W:0]          total_sum;
	logic [BIN_AW-1:0]                bin_q;
	logic signed [bhm_pkg::VAL_W-1:0] bin_value_q;

	logic                             res_valid_q;
	bhm_pkg::res_t                    res_q;
	bhm_pkg::res_t                    res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= bhm_pkg::VAL_W'(15);
			step_q <= bhm_pkg::STEP_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				bhm_pkg::CFG_LOW:  low_q  <= cfg_data;
				bhm_pkg::CFG_HIGH: high_q <= cfg_data;
				bhm_pkg::CFG_STEP: step_q <= cfg_data[bhm_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_in;
		end
	end

	assign step_eff = (step_q == '0) ? bhm_pkg::STEP_W'(1) : step_q;
	assign d1       = {cmd_q.value[bhm_pkg::VAL_W-1], cmd_q.value} - {low_q[bhm_pkg::VAL_W-1], low_q};
	assign d2       = {high_q[bhm_pkg::VAL_W-1], high_q} - {low_q[bhm_pkg::VAL_W-1], low_q};
	assign d1_neg   = -d1;
	assign mag1     = d1[bhm_pkg::VAL_W] ? d1_neg[bhm_pkg::VAL_W-1:0] : d1[bhm_pkg::VAL_W-1:0];
	assign mag2     = d2[bhm_pkg::VAL_W-1:0];

	bhm_div u_div_val (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (mag1),
		.divisor   (step_eff),
		.busy      (busy1),
		.quotient  (q1),
		.remainder (r1)
	);

	bhm_div u_div_nb (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (mag2),
		.divisor   (step_eff),
		.busy      (busy2),
		.quotient  (q2),
		.remainder (r2_unused)
	);

	assign q2p1 = (bhm_pkg::VAL_W + 1)'(q2) + (bhm_pkg::VAL_W + 1)'(1);

	always_comb begin
		if (d2[bhm_pkg::VAL_W]) begin
			nb_d = '0;
		end else if (q2p1 > (bhm_pkg::VAL_W + 1)'(BINS)) begin
			nb_d = NB_W'(BINS);
		end else begin
			nb_d = NB_W'(q2p1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.nb_load) begin
			nb_q <= nb_d;
		end
	end

	assign bad_range = (d1[bhm_pkg::VAL_W] && (q1 != '0))
		|| ((bhm_pkg::VAL_W + 1)'(q1) >= (bhm_pkg::VAL_W + 1)'(nb_q))
		|| ({1'b0, cmd_q.run} >= 3'(RUNS));
	assign k = q1[BIN_AW-1:0];

	assign raddr = ctl.addr_dump ? bin_q : k;
	assign waddr = ctl.clr ? clr_q : k;
	assign wdata = ctl.clr ? '0 : ROW_W'(lanes_upd);

	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr) begin
			clr_q <= clr_q + BIN_AW'(1);
		end
	end

	assign lanes   = LANE_W'(rdata_q);
	assign sel_cnt = lanes[cmd_q.run * CW +: CW];
	assign sel_inc = (sel_cnt == '1) ? sel_cnt : sel_cnt + CW'(1);

	always_comb begin
		lanes_upd = lanes;
		lanes_upd[cmd_q.run * CW +: CW] = sel_inc;
	end

	always_comb begin
		row_sum = '0;
		for (int r = 0; r < bhm_pkg::MAX_RUNS; r++) begin
			row_sum = row_sum + bhm_pkg::RSUM_W'(lanes[r * CW +: CW]);
		end
	end

	assign total_sum = (bhm_pkg::TOT_W + 1)'(total_q) + (bhm_pkg::TOT_W + 1)'(row_sum_q);

	always_ff @(posedge clk) begin
		if (ctl.rowsum_load) begin
			row_sum_q <= row_sum;
		end
		if (ctl.dump_init) begin
			total_q     <= '0;
			bin_q       <= '0;
			bin_value_q <= low_q;
		end else if (ctl.dump_adv) begin
			total_q     <= total_sum[bhm_pkg::TOT_W] ? '1 : total_sum[bhm_pkg::TOT_W-1:0];
			bin_q       <= bin_q + BIN_AW'(1);
			bin_value_q <= bin_value_q + bhm_pkg::VAL_W'(step_eff);
		end
	end

	always_comb begin
		res_d = '0;
		case (ctl.out_kind)
			bhm_pkg::OUT_ERR: begin
				res_d.error   = 1'b1;
				res_d.is_last = 1'b1;
			end
			bhm_pkg::OUT_ACK: begin
				res_d.is_last = 1'b1;
			end
			bhm_pkg::OUT_READ: begin
				res_d.count_0 = sel_cnt;
				res_d.is_last = 1'b1;
			end
			bhm_pkg::OUT_ROW: begin
				res_d.bin_value = bin_value_q;
				res_d.count_0   = lanes[0 * CW +: CW];
				res_d.count_1   = lanes[1 * CW +: CW];
				res_d.count_2   = lanes[2 * CW +: CW];
				res_d.count_3   = lanes[3 * CW +: CW];
			end
			bhm_pkg::OUT_FINAL: begin
				res_d.grand_total = total_q;
				res_d.is_last     = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (ctl.out_kind != bhm_pkg::OUT_NONE);
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign sts.div_busy  = busy1 || busy2;
	assign sts.bad       = bad_range || ((cmd_q.opcode == bhm_pkg::OP_READ) && (r1 != '0));
	assign sts.op        = cmd_q.opcode;
	assign sts.row_nz    = (rdata_q != '0);
	assign sts.dump_last = ((NB_W'(bin_q) + NB_W'(1)) == nb_q);
	assign sts.nb_zero   = (nb_q == '0);
	assign sts.clr_last  = (clr_q == BIN_AW'(BINS - 1));

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### src/binned_histogram_multi_run_core.sv
// Channel  | Handshake                    | Payload
// ---------+------------------------------+------------------------------------
// command  | start, busy (start & !busy)  | cmd : opcode, value, run
// result   | res_valid, one cycle strobe  | res : bin_value, count_0..3,
//          |                              |       grand_total, is_last, error
// config   | cfg_valid, cfg_ready         | cfg_index, cfg_data
//
// Count and read pass through states DSTART, DIV, NB, CHK and RD, or end
// at CHK on an error; the two 16-step bit-serial dividers (value bin and
// bin count) run in DIV. A dump then reads one memory row per bin in range.
// After reset a clearing pass writes BINS rows, one per cycle, with busy high.
// Results cannot be held off; busy drops in the cycle the last result shows.
`default_nettype none

module binned_histogram_multi_run_core #(
	parameter int BINS = bhm_pkg::BINS_DEF,
	parameter int RUNS = bhm_pkg::RUNS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire bhm_pkg::cmd_t                 cmd,
	output logic                               res_valid,
	output bhm_pkg::res_t                      res,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bhm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bhm_pkg::VAL_W-1:0]     cfg_data
);

	bhm_pkg::ctrl_t   ctl;
	bhm_pkg::status_t sts;
	logic             busy_c;

	assign cfg_ready = 1'b1;

	bhm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy_c),
		.sts    (sts),
		.ctl    (ctl)
	);

	bhm_datapath #(
		.BINS (BINS),
		.RUNS (RUNS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.res_valid (res_valid),
		.res       (res)
	);

	assign busy = busy_c;

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_last |-> !busy)
		else $error("final item shown while busy");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !res_valid)
		else $error("item shown right after accept");

	a_row_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.is_last |-> (res.grand_total == '0) && !res.error)
		else $error("dump row carries total or error");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.error |-> (res.count_0 == '0))
		else $error("error item carries a count");

endmodule

`default_nettype wire
